// ----- design/vcor_pkg.sv -----
// vcor_pkg: shared types, codes and constants of the voxel column occlusion raster
// used by every design file but vcor_if; depends on nothing
`timescale 1ns / 1ps

package vcor_pkg;

  // default geometry
  localparam int unsigned COLUMNS_DEF     = 320;
  localparam int unsigned SCREEN_ROWS_DEF = 200;
  localparam int unsigned RANGE_STEPS_DEF = 240;

  // projection and haze
  localparam int unsigned SCALE_SHIFT = 11;
  localparam int unsigned PROJ_W      = 16;
  localparam int unsigned HAZE_MAX    = 63;

  // span widths in pixels
  localparam logic [2:0] SPAN_W_CLOSE = 3'd4;
  localparam logic [2:0] SPAN_W_MID   = 3'd2;
  localparam logic [2:0] SPAN_W_FAR   = 3'd1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEWER_HEIGHT = 3'd0,
    CFG_HORIZON_ROW   = 3'd1,
    CFG_WATER_LINE    = 3'd2,
    CFG_CLOSE_STEP    = 3'd3,
    CFG_MID_STEP      = 3'd4,
    CFG_HAZE_STEP     = 3'd5
  } cfg_idx_e;

  localparam logic [8:0] VIEWER_HEIGHT_RST = 9'd32;
  localparam logic [7:0] HORIZON_ROW_RST   = 8'd140;
  localparam logic [7:0] WATER_LINE_RST    = 8'd1;
  localparam logic [7:0] CLOSE_STEP_RST    = 8'd48;
  localparam logic [7:0] MID_STEP_RST      = 8'd128;
  localparam logic [7:0] HAZE_STEP_RST     = 8'd192;

  typedef struct packed {
    logic [8:0] viewer_height;
    logic [7:0] horizon_row;
    logic [7:0] water_line;
    logic [7:0] close_step;
    logic [7:0] mid_step;
    logic [7:0] haze_step;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_COPY4  = 2'd2,
    OP_COPY2  = 2'd3
  } op_e;

  // fixed-width part of a queued request
  typedef struct packed {
    op_e         op;
    logic [15:0] colour;
    logic [2:0]  width;
    logic [5:0]  haze;
  } cmd_fix_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// ----- design/vcor_if.sv -----
// vcor_if: valid/ready channel interfaces for sample requests and span results
// field widths follow the fixed item formats; no package dependency
`timescale 1ns / 1ps

interface vcor_sample_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [8:0]  column;
  logic [7:0]  range_step;
  logic [7:0]  terrain_height;
  logic [14:0] height_scale;
  logic [15:0] land_colour;
  logic [15:0] water_colour;

  modport source (
    output valid, operation, column, range_step, terrain_height, height_scale,
           land_colour, water_colour,
    input  ready
  );
  modport sink (
    input  valid, operation, column, range_step, terrain_height, height_scale,
           land_colour, water_colour,
    output ready
  );
endinterface

interface vcor_span_if;
  logic        valid;
  logic        ready;
  logic [7:0]  span_start;
  logic [7:0]  span_rows;
  logic [15:0] span_colour;
  logic [2:0]  span_width;
  logic [5:0]  haze_level;

  modport source (
    output valid, span_start, span_rows, span_colour, span_width, haze_level,
    input  ready
  );
  modport sink (
    input  valid, span_start, span_rows, span_colour, span_width, haze_level,
    output ready
  );
endinterface

// ----- design/voxel_column_occlusion_raster.sv -----
// voxel_column_occlusion_raster: top level with configuration registers and checks
// depends on vcor_pkg, vcor_if, vcor_front, vcor_queue and vcor_back
`timescale 1ns / 1ps

// The front stage takes one request per cycle into a two-entry queue, unless the
// queue is full or the initial clear runs. The back stage owns the occlusion
// memory and sets the rate: a sample is a memory read, then a compare and update,
// and a clear or a copy sweeps the columns. After reset the back stage clears
// the memory, with no request accepted meanwhile; configuration writes are taken at
// any time. A span waits in an output register while the back stage moves on to
// the next request; a further span stalls the back stage until that register frees.
module voxel_column_occlusion_raster #(
  parameter int unsigned COLUMNS     = vcor_pkg::COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS = vcor_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned RANGE_STEPS = vcor_pkg::RANGE_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  vcor_sample_if.sink                       sample_i,
  vcor_span_if.source                       span_o,
  input  logic                              cfg_we_i,
  input  logic [vcor_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vcor_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned TOP_W = $clog2(SCREEN_ROWS + 2);
  localparam int unsigned CMD_W = COL_W + TOP_W + $bits(vcor_pkg::cmd_fix_t);

  vcor_pkg::cfg_t       cfg_q, cfg_d;
  vcor_pkg::back_stat_t stat;

  logic             push_valid, push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [CMD_W-1:0] pop_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vcor_pkg::cfg_idx_e'(cfg_index_i))
        vcor_pkg::CFG_VIEWER_HEIGHT: cfg_d.viewer_height = cfg_wdata_i;
        vcor_pkg::CFG_HORIZON_ROW:   cfg_d.horizon_row   = cfg_wdata_i[7:0];
        vcor_pkg::CFG_WATER_LINE:    cfg_d.water_line    = cfg_wdata_i[7:0];
        vcor_pkg::CFG_CLOSE_STEP:    cfg_d.close_step    = cfg_wdata_i[7:0];
        vcor_pkg::CFG_MID_STEP:      cfg_d.mid_step      = cfg_wdata_i[7:0];
        vcor_pkg::CFG_HAZE_STEP:     cfg_d.haze_step     = cfg_wdata_i[7:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.viewer_height <= vcor_pkg::VIEWER_HEIGHT_RST;
      cfg_q.horizon_row   <= vcor_pkg::HORIZON_ROW_RST;
      cfg_q.water_line    <= vcor_pkg::WATER_LINE_RST;
      cfg_q.close_step    <= vcor_pkg::CLOSE_STEP_RST;
      cfg_q.mid_step      <= vcor_pkg::MID_STEP_RST;
      cfg_q.haze_step     <= vcor_pkg::HAZE_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vcor_front #(
    .COLUMNS     (COLUMNS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .RANGE_STEPS (RANGE_STEPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cfg_i       (cfg_q),
    .stat_i      (stat),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_data)
  );

  vcor_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  vcor_back #(
    .COLUMNS     (COLUMNS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .span_o      (span_o),
    .stat_o      (stat)
  );

  // no request taken while the buffer is being cleared after reset
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.init_busy |-> !(sample_i.valid && sample_i.ready))
    else $error("request accepted during initial clear");

  // no span can leave before the first clearing pass ends
  a_no_span_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.init_busy |-> !span_o.valid)
    else $error("span produced during initial clear");

  // haze only on far, single-pixel spans
  a_haze_far_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_o.valid && (span_o.haze_level != 6'd0)) |-> (span_o.span_width == 3'd1))
    else $error("haze on a wide span");

  // a full queue that is not drained does not go empty
  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_ready && !pop_ready) |=> pop_valid)
    else $error("queue lost its contents");

endmodule

// ----- design/vcor_front.sv -----
// vcor_front: accepts requests, projects height to a row, picks colour, width and haze
// depends on vcor_pkg and vcor_sample_if; feeds the request queue
`timescale 1ns / 1ps

module vcor_front #(
  parameter int unsigned COLUMNS     = vcor_pkg::COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS = vcor_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned RANGE_STEPS = vcor_pkg::RANGE_STEPS_DEF,
  localparam int unsigned COL_W      = $clog2(COLUMNS),
  localparam int unsigned TOP_W      = $clog2(SCREEN_ROWS + 2),
  localparam int unsigned CMD_W      = COL_W + TOP_W + $bits(vcor_pkg::cmd_fix_t)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vcor_sample_if.sink          sample_i,
  input  vcor_pkg::cfg_t       cfg_i,
  input  vcor_pkg::back_stat_t stat_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output logic [CMD_W-1:0]     cmd_o
);

  logic        s1_valid_q, s1_valid_d;
  vcor_pkg::op_e s1_op_q;
  logic [8:0]  s1_col_q;
  logic [7:0]  s1_step_q;
  logic [7:0]  s1_hm_q;
  logic [14:0] s1_scale_q;
  logic [15:0] s1_land_q;
  logic [15:0] s1_water_q;

  logic        keep;
  logic        advance;
  logic        accept;

  logic signed [9:0]  diff;
  logic signed [25:0] diff_x;
  logic signed [25:0] scale_x;
  logic signed [25:0] prod;
  logic signed [vcor_pkg::PROJ_W-1:0] proj;
  logic signed [vcor_pkg::PROJ_W-1:0] row_s;
  logic [TOP_W-1:0]   row;

  logic [COL_W+8:0]   col_wide;
  logic [COL_W-1:0]   col_idx;

  logic [7:0] haze_diff;
  logic [9:0] haze_x3;
  logic [8:0] haze_half;
  vcor_pkg::cmd_fix_t fix;

  // sample in range or any buffer operation goes to the queue
  assign keep = (s1_op_q != vcor_pkg::OP_SAMPLE) ||
                ((32'(s1_col_q) < 32'(COLUMNS)) && (32'(s1_step_q) < 32'(RANGE_STEPS)));
  assign advance  = s1_valid_q && (!keep || cmd_ready_i);
  assign sample_i.ready = !stat_i.init_busy && (!s1_valid_q || advance);
  assign accept   = sample_i.valid && sample_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= vcor_pkg::op_e'(sample_i.operation);
      s1_col_q   <= sample_i.column;
      s1_step_q  <= sample_i.range_step;
      s1_hm_q    <= sample_i.terrain_height;
      s1_scale_q <= sample_i.height_scale;
      s1_land_q  <= sample_i.land_colour;
      s1_water_q <= sample_i.water_colour;
    end
  end

  // projection, floor division by arithmetic shift
  assign diff    = $signed({2'b00, s1_hm_q}) - $signed({1'b0, cfg_i.viewer_height});
  assign diff_x  = 26'(diff);
  assign scale_x = 26'($signed({1'b0, s1_scale_q}));
  assign prod    = diff_x * scale_x;
  assign proj    = vcor_pkg::PROJ_W'(prod >>> vcor_pkg::SCALE_SHIFT);
  assign row_s   = proj + $signed({8'b0, cfg_i.horizon_row});

  always_comb begin
    if (row_s < 0) begin
      row = '0;
    end else if (row_s > $signed(vcor_pkg::PROJ_W'(SCREEN_ROWS + 1))) begin
      row = TOP_W'(SCREEN_ROWS + 1);
    end else begin
      row = TOP_W'(row_s);
    end
  end

  assign col_wide = {{COL_W{1'b0}}, s1_col_q};
  assign col_idx  = col_wide[COL_W-1:0];

  assign haze_diff = s1_step_q - cfg_i.haze_step;
  assign haze_x3   = {1'b0, haze_diff, 1'b0} + {2'b00, haze_diff};
  assign haze_half = haze_x3[9:1];

  always_comb begin
    fix.op     = s1_op_q;
    fix.colour = (s1_hm_q > cfg_i.water_line) ? s1_land_q : s1_water_q;
    fix.haze   = '0;
    priority if (s1_step_q < cfg_i.close_step) begin
      fix.width = vcor_pkg::SPAN_W_CLOSE;
    end else if (s1_step_q < cfg_i.mid_step) begin
      fix.width = vcor_pkg::SPAN_W_MID;
    end else begin
      fix.width = vcor_pkg::SPAN_W_FAR;
      if (s1_step_q >= cfg_i.haze_step) begin
        fix.haze = (haze_half > 9'(vcor_pkg::HAZE_MAX)) ? 6'(vcor_pkg::HAZE_MAX)
                                                        : haze_half[5:0];
      end
    end
  end

  assign cmd_valid_o = s1_valid_q && keep;
  assign cmd_o       = {col_idx, row, fix};

endmodule

// ----- design/vcor_queue.sv -----
// vcor_queue: two-entry request queue between front and back
// depends on vcor_pkg for its default width
`timescale 1ns / 1ps

module vcor_queue #(
  parameter int unsigned W = $bits(vcor_pkg::cmd_fix_t)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] ent_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/vcor_back.sv -----
// vcor_back: occlusion buffer memory, sample compare/update, clear and copy sweeps
// depends on vcor_pkg and vcor_span_if; drains the request queue
`timescale 1ns / 1ps

module vcor_back #(
  parameter int unsigned COLUMNS     = vcor_pkg::COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS = vcor_pkg::SCREEN_ROWS_DEF,
  localparam int unsigned COL_W      = $clog2(COLUMNS),
  localparam int unsigned TOP_W      = $clog2(SCREEN_ROWS + 2),
  localparam int unsigned PTR_W      = COL_W + 1,
  localparam int unsigned FIX_W      = $bits(vcor_pkg::cmd_fix_t),
  localparam int unsigned CMD_W      = COL_W + TOP_W + FIX_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  logic [CMD_W-1:0]     cmd_i,
  vcor_span_if.source          span_o,
  output vcor_pkg::back_stat_t stat_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SAMPLE = 5'b00100,
    ST_CPRD   = 5'b01000,
    ST_CPWR   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [1:0]       k_q, k_d;
  logic [1:0]       klast_q, klast_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [TOP_W-1:0] row_q, row_d;
  vcor_pkg::cmd_fix_t fix_q, fix_d;
  logic             init_q, init_d;

  logic [COL_W-1:0]   cmd_col;
  logic [TOP_W-1:0]   cmd_row;
  vcor_pkg::cmd_fix_t cmd_fix;

  logic [TOP_W-1:0] mem_q [COLUMNS];
  logic [TOP_W-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [COL_W-1:0] mem_waddr, mem_raddr;
  logic [TOP_W-1:0] mem_wdata;

  logic [PTR_W-1:0] cp_addr;
  logic [PTR_W-1:0] cp_next;
  logic [PTR_W-1:0] last_col;
  logic             hit;
  logic             out_free;
  logic             span_load;

  logic        span_valid_q, span_valid_d;
  logic [7:0]  span_start_q;
  logic [7:0]  span_rows_q;
  logic [15:0] span_colour_q;
  logic [2:0]  span_width_q;
  logic [5:0]  haze_level_q;

  assign cmd_col = cmd_i[CMD_W-1 -: COL_W];
  assign cmd_row = cmd_i[FIX_W +: TOP_W];
  assign cmd_fix = vcor_pkg::cmd_fix_t'(cmd_i[FIX_W-1:0]);

  assign last_col = PTR_W'(COLUMNS - 1);
  assign cp_addr  = ptr_q + PTR_W'(k_q);
  assign cp_next  = ptr_q + PTR_W'(klast_q) + PTR_W'(1);
  assign hit      = (rdata_q <= TOP_W'(SCREEN_ROWS)) && (row_q > rdata_q);
  assign out_free = !span_valid_q || span_o.ready;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    k_d         = k_q;
    klast_d     = klast_q;
    col_d       = col_q;
    row_d       = row_q;
    fix_d       = fix_q;
    init_d      = init_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q[COL_W-1:0];
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[COL_W-1:0];
    span_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          col_d = cmd_col;
          row_d = cmd_row;
          fix_d = cmd_fix;
          ptr_d = '0;
          k_d   = 2'd1;
          unique case (cmd_fix.op)
            vcor_pkg::OP_CLEAR: state_d = ST_CLEAR;
            vcor_pkg::OP_SAMPLE: begin
              mem_re    = 1'b1;
              mem_raddr = cmd_col;
              state_d   = ST_SAMPLE;
            end
            vcor_pkg::OP_COPY4: begin
              klast_d = 2'd3;
              state_d = ST_CPRD;
            end
            vcor_pkg::OP_COPY2: begin
              klast_d = 2'd1;
              state_d = ST_CPRD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr_q == last_col) begin
          ptr_d   = '0;
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      ST_SAMPLE: begin
        if (!hit) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = col_q;
          mem_wdata = row_q;
          span_load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_CPRD: begin
        // a lone last column has nothing to copy into
        if (ptr_q == last_col) begin
          state_d = ST_IDLE;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_CPWR;
        end
      end
      ST_CPWR: begin
        mem_we    = 1'b1;
        mem_waddr = cp_addr[COL_W-1:0];
        mem_wdata = rdata_q;
        if ((k_q == klast_q) || (cp_addr == last_col)) begin
          k_d     = 2'd1;
          ptr_d   = cp_next;
          state_d = (cp_next >= PTR_W'(COLUMNS)) ? ST_IDLE : ST_CPRD;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    span_valid_d = span_valid_q;
    if (span_load) begin
      span_valid_d = 1'b1;
    end else if (span_o.ready) begin
      span_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      ptr_q        <= '0;
      k_q          <= 2'd1;
      klast_q      <= 2'd1;
      init_q       <= 1'b1;
      span_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      k_q          <= k_d;
      klast_q      <= klast_d;
      init_q       <= init_d;
      span_valid_q <= span_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    row_q <= row_d;
    fix_q <= fix_d;
    if (span_load) begin
      span_start_q  <= 8'(rdata_q);
      span_rows_q   <= 8'(row_q - rdata_q);
      span_colour_q <= fix_q.colour;
      span_width_q  <= fix_q.width;
      haze_level_q  <= fix_q.haze;
    end
  end

  // occlusion buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign span_o.valid       = span_valid_q;
  assign span_o.span_start  = span_start_q;
  assign span_o.span_rows   = span_rows_q;
  assign span_o.span_colour = span_colour_q;
  assign span_o.span_width  = span_width_q;
  assign span_o.haze_level  = haze_level_q;

  assign stat_o.init_busy = init_q;

endmodule

// ----- tb/voxel_column_occlusion_raster_tb.sv -----
// voxel_column_occlusion_raster_tb: self-checking bench for the voxel column occlusion raster
// a span predictor class tracks the occlusion buffer and checks each span in order
// depends on vcor_pkg, vcor_if and the voxel_column_occlusion_raster top level
`timescale 1ns / 1ps

module voxel_column_occlusion_raster_tb;
  import vcor_pkg::*;

  localparam int unsigned N_COLUMNS     = COLUMNS_DEF;
  localparam int unsigned N_SCREEN_ROWS = SCREEN_ROWS_DEF;
  localparam int unsigned N_RANGE_STEPS = RANGE_STEPS_DEF;
  localparam longint      ROW_CAP       = longint'(N_SCREEN_ROWS) + 1;
  localparam int unsigned Q18_ONE       = 262144;
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES  = 4 * (N_COLUMNS + N_COLUMNS / 2) + 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    op_e         op;
    logic [8:0]  column;
    logic [7:0]  range_step;
    logic [7:0]  terrain_height;
    logic [14:0] height_scale;
    logic [15:0] land_colour;
    logic [15:0] water_colour;
  } sample_t;

  typedef struct packed {
    logic [7:0]  start;
    logic [7:0]  rows;
    logic [15:0] colour;
    logic [2:0]  width;
    logic [5:0]  haze;
  } span_t;

  class span_predictor;
    logic [8:0] col_top [N_COLUMNS];
    logic [8:0] viewer_height;
    logic [7:0] horizon_row;
    logic [7:0] water_line;
    logic [7:0] close_step;
    logic [7:0] mid_step;
    logic [7:0] haze_step;
    span_t expected_spans [$];
    int unsigned errors;
    int unsigned spans_checked;

    function new();
      viewer_height = VIEWER_HEIGHT_RST;
      horizon_row   = HORIZON_ROW_RST;
      water_line    = WATER_LINE_RST;
      close_step    = CLOSE_STEP_RST;
      mid_step      = MID_STEP_RST;
      haze_step     = HAZE_STEP_RST;
      foreach (col_top[i]) col_top[i] = '0;
      errors        = 0;
      spans_checked = 0;
    endfunction

    function int unsigned pending();
      return expected_spans.size();
    endfunction

    function string span_str(input span_t s);
      return $sformatf("start=%0d rows=%0d colour=%h width=%0d haze=%0d",
                       s.start, s.rows, s.colour, s.width, s.haze);
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIEWER_HEIGHT: viewer_height = data;
        CFG_HORIZON_ROW:   horizon_row   = data[7:0];
        CFG_WATER_LINE:    water_line    = data[7:0];
        CFG_CLOSE_STEP:    close_step    = data[7:0];
        CFG_MID_STEP:      mid_step      = data[7:0];
        CFG_HAZE_STEP:     haze_step     = data[7:0];
        default: ;
      endcase
    endfunction

    // last group stops at the last column
    function void copy_groups(input int unsigned stride);
      for (int unsigned j = 0; j < N_COLUMNS; j += stride)
        for (int unsigned k = 1; k < stride && j + k < N_COLUMNS; k++)
          col_top[j + k] = col_top[j];
    endfunction

    function void note_request(input sample_t s);
      logic [8:0] top;
      longint     prod;
      longint     row;
      int         haze;
      span_t      sp;
      case (s.op)
        OP_CLEAR: foreach (col_top[i]) col_top[i] = '0;
        OP_COPY4: copy_groups(4);
        OP_COPY2: copy_groups(2);
        OP_SAMPLE: begin
          if (s.column < N_COLUMNS && s.range_step < N_RANGE_STEPS) begin
            top  = col_top[s.column];
            prod = (longint'(s.terrain_height) - longint'(viewer_height)) *
                   longint'(s.height_scale);
            // arithmetic shift floors negative products
            row  = (prod >>> SCALE_SHIFT) + longint'(horizon_row);
            if (row > ROW_CAP) row = ROW_CAP;
            if (top <= N_SCREEN_ROWS && row > longint'(top)) begin
              haze = 0;
              if (s.range_step < close_step) begin
                sp.width = SPAN_W_CLOSE;
              end else if (s.range_step < mid_step) begin
                sp.width = SPAN_W_MID;
              end else begin
                sp.width = SPAN_W_FAR;
                if (s.range_step >= haze_step) begin
                  haze = (3 * (int'(s.range_step) - int'(haze_step))) / 2;
                  if (haze > int'(HAZE_MAX)) haze = int'(HAZE_MAX);
                end
              end
              sp.start  = top[7:0];
              sp.rows   = 8'(row - longint'(top));
              sp.colour = (s.terrain_height > water_line) ? s.land_colour : s.water_colour;
              sp.haze   = 6'(haze);
              col_top[s.column] = row[8:0];
              expected_spans.push_back(sp);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_span(input span_t got);
      span_t want;
      spans_checked++;
      if (expected_spans.size() == 0) begin
        flag({"span with none expected: ", span_str(got)});
        return;
      end
      want = expected_spans.pop_front();
      if (got.start !== want.start || got.rows !== want.rows ||
          got.colour !== want.colour || got.width !== want.width ||
          got.haze !== want.haze)
        flag({"span expected ", span_str(want), " got ", span_str(got)});
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  vcor_sample_if sample_bus ();
  vcor_span_if   span_bus ();

  voxel_column_occlusion_raster dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_bus),
    .span_o      (span_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  span_predictor model;
  bit            idle_en;
  int unsigned   stall_left;
  int unsigned   quiet_cycles;
  int unsigned   useful_items;
  int unsigned   n_samples;
  int unsigned   n_ignored;
  int unsigned   n_clears;
  int unsigned   n_copies;
  int unsigned   n_settings;

  always #CLK_HALF clk_i = ~clk_i;

  // span receiver with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left     <= stall_left - 1;
      span_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < 10) begin
      stall_left     <= $urandom_range(0, 16);
      span_bus.ready <= 1'b0;
    end else begin
      span_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (sample_bus.valid && sample_bus.ready)
        model.note_request('{op: op_e'(sample_bus.operation),
                             column: sample_bus.column,
                             range_step: sample_bus.range_step,
                             terrain_height: sample_bus.terrain_height,
                             height_scale: sample_bus.height_scale,
                             land_colour: sample_bus.land_colour,
                             water_colour: sample_bus.water_colour});
      if (span_bus.valid && span_bus.ready)
        model.check_span('{start: span_bus.span_start, rows: span_bus.span_rows,
                           colour: span_bus.span_colour, width: span_bus.span_width,
                           haze: span_bus.haze_level});
    end
  end

  always @(posedge clk_i) begin
    if ((sample_bus.valid && sample_bus.ready) || (span_bus.valid && span_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d spans outstanding",
               WATCHDOG_LIMIT, model.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic sample_t make_request(input op_e op, input int unsigned col,
                                           input int unsigned step, input int unsigned hm,
                                           input int unsigned scale, input int unsigned land,
                                           input int unsigned water);
    sample_t s;
    s.op             = op;
    s.column         = 9'(col);
    s.range_step     = 8'(step);
    s.terrain_height = 8'(hm);
    s.height_scale   = 15'(scale);
    s.land_colour    = 16'(land);
    s.water_colour   = 16'(water);
    return s;
  endfunction

  function automatic sample_t noise_request();
    return make_request(op_e'($urandom_range(0, 3)), $urandom_range(0, 511),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 32767), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
  endfunction

  // perspective-like scale, heights often straddling sea level
  function automatic sample_t frame_sample(input int unsigned col, input int unsigned step);
    int unsigned hm;
    int unsigned scale;
    if ($urandom_range(0, 3) == 0) hm = (model.water_line + $urandom_range(0, 2) - 1) & 255;
    else hm = $urandom_range(0, 255);
    scale = Q18_ONE / (step + 16);
    if ($urandom_range(0, 7) == 0) scale = $urandom_range(0, 16384);
    return make_request(OP_SAMPLE, col, step, hm, scale, $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
  endfunction

  task automatic send_request(input sample_t s);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      sample_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_bus.valid          <= 1'b1;
    sample_bus.operation      <= s.op;
    sample_bus.column         <= s.column;
    sample_bus.range_step     <= s.range_step;
    sample_bus.terrain_height <= s.terrain_height;
    sample_bus.height_scale   <= s.height_scale;
    sample_bus.land_colour    <= s.land_colour;
    sample_bus.water_colour   <= s.water_colour;
    do @(posedge clk_i); while (!sample_bus.ready);
    case (s.op)
      OP_CLEAR: n_clears++;
      OP_COPY4, OP_COPY2: n_copies++;
      default: begin
        if (s.column < N_COLUMNS && s.range_step < N_RANGE_STEPS) n_samples++;
        else n_ignored++;
      end
    endcase
    if (s.op != OP_SAMPLE || (s.column < N_COLUMNS && s.range_step < N_RANGE_STEPS))
      useful_items++;
  endtask

  // hold off requests until all spans are back and the back stage is done
  task automatic drain();
    @(negedge clk_i);
    sample_bus.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    model.write_reg(idx, data);
  endtask

  // upper data bit is junk for the 8-bit registers
  task automatic program_regs(input logic [8:0] vh, input logic [7:0] hr, input logic [7:0] sea,
                              input logic [7:0] cs, input logic [7:0] ms, input logic [7:0] hs);
    write_one(CFG_SPARE_A, 9'($urandom_range(0, 511)));
    write_one(CFG_VIEWER_HEIGHT, vh);
    write_one(CFG_HORIZON_ROW, {1'($urandom_range(0, 1)), hr});
    write_one(CFG_WATER_LINE, {1'($urandom_range(0, 1)), sea});
    write_one(CFG_CLOSE_STEP, {1'($urandom_range(0, 1)), cs});
    write_one(CFG_MID_STEP, {1'($urandom_range(0, 1)), ms});
    write_one(CFG_HAZE_STEP, {1'($urandom_range(0, 1)), hs});
    write_one(CFG_SPARE_B, 9'($urandom_range(0, 511)));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // clear, then march range steps front to back over a few adjacent columns, with copies
  task automatic run_frame();
    sample_t     s;
    int unsigned step;
    int unsigned prev_step;
    int unsigned first_col;
    int unsigned ncols;
    int unsigned budget;
    int unsigned n;
    s = noise_request();
    s.op = OP_CLEAR;
    send_request(s);
    step      = $urandom_range(0, 8);
    prev_step = step;
    first_col = $urandom_range(0, N_COLUMNS - 1);
    ncols     = $urandom_range(1, 6);
    budget    = $urandom_range(15, 60);
    n         = 0;
    while (step < N_RANGE_STEPS && n < budget) begin
      if (prev_step < model.close_step && step >= model.close_step) begin
        s = noise_request();
        s.op = OP_COPY4;
        send_request(s);
      end
      if (prev_step < model.mid_step && step >= model.mid_step) begin
        s = noise_request();
        s.op = OP_COPY2;
        send_request(s);
      end
      for (int unsigned c = 0; c < ncols; c++) begin
        send_request(frame_sample((first_col + c) % N_COLUMNS, step));
        n++;
      end
      prev_step = step;
      step += $urandom_range(1, 20);
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned goal;
    int unsigned n;
    goal = useful_items + budget;
    while (useful_items < goal) begin
      if ($urandom_range(0, 99) < 80) begin
        run_frame();
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_request(noise_request());
      end
    end
  endtask

  initial begin
    model        = new();
    idle_en      = 1'b1;
    stall_left   = 0;
    quiet_cycles = 0;
    useful_items = 0;
    n_samples    = 0;
    n_ignored    = 0;
    n_clears     = 0;
    n_copies     = 0;
    n_settings   = 0;
    sample_bus.valid          = 1'b0;
    sample_bus.operation      = OP_CLEAR;
    sample_bus.column         = '0;
    sample_bus.range_step     = '0;
    sample_bus.terrain_height = '0;
    sample_bus.height_scale   = '0;
    sample_bus.land_colour    = '0;
    sample_bus.water_colour   = '0;
    span_bus.ready            = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_index_i               = '0;
    cfg_wdata_i               = '0;
    rst_ni                    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, boundaries, occlusion, copies, under reset settings
    send_request(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_SAMPLE, 0, 0, 255, 16384, 16'hffff, 16'h0000));
    send_request(make_request(OP_SAMPLE, 0, 5, 255, 16384, 16'h1234, 16'h4321));
    send_request(make_request(OP_SAMPLE, 319, 239, 0, 0, 16'h0000, 16'hffff));
    send_request(make_request(OP_SAMPLE, 320, 10, 255, 16384, 16'h00ff, 16'hff00));
    send_request(make_request(OP_SAMPLE, 511, 10, 255, 16384, 16'h00ff, 16'hff00));
    send_request(make_request(OP_SAMPLE, 1, 240, 255, 16384, 16'h0f0f, 16'hf0f0));
    send_request(make_request(OP_SAMPLE, 1, 255, 255, 32767, 16'h0f0f, 16'hf0f0));
    send_request(make_request(OP_SAMPLE, 2, 47, 1, 32767, 16'haaaa, 16'h5555));
    send_request(make_request(OP_SAMPLE, 3, 48, 30, 1000, 16'h5555, 16'haaaa));
    send_request(make_request(OP_SAMPLE, 4, 127, 2, 4096, 16'hbeef, 16'hcafe));
    send_request(make_request(OP_SAMPLE, 5, 128, 100, 2048, 16'h8001, 16'h7ffe));
    send_request(make_request(OP_SAMPLE, 6, 192, 40, 256, 16'h0001, 16'h8000));
    send_request(make_request(OP_SAMPLE, 6, 193, 41, 2048, 16'h0002, 16'h4000));
    send_request(make_request(OP_SAMPLE, 6, 200, 30, 2048, 16'h0004, 16'h2000));
    send_request(make_request(OP_COPY4, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_SAMPLE, 7, 210, 200, 1024, 16'h0008, 16'h1000));
    send_request(make_request(OP_COPY2, 511, 255, 255, 32767, 16'hffff, 16'hffff));
    send_request(make_request(OP_SAMPLE, 319, 100, 255, 16384, 16'h0010, 16'h0800));
    send_request(make_request(OP_CLEAR, 511, 255, 255, 32767, 16'hffff, 16'hffff));
    send_request(make_request(OP_SAMPLE, 100, 0, 32, 16384, 16'h0020, 16'h0400));
    send_request(make_request(OP_SAMPLE, 100, 1, 33, 2047, 16'h0040, 16'h0200));
    send_request(make_request(OP_SAMPLE, 100, 2, 33, 2048, 16'h0080, 16'h0100));

    drain();
    program_regs(9'($urandom_range(0, 160)), 8'($urandom_range(60, 200)),
                 8'($urandom_range(0, 120)), 8'($urandom_range(16, 80)),
                 8'($urandom_range(80, 180)), 8'($urandom_range(100, 230)));
    run_phase(PHASE_ITEMS);

    drain();
    program_regs(9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_phase(PHASE_ITEMS);

    drain();
    idle_en = 1'b0;
    program_regs(9'd511, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_phase(PHASE_ITEMS);

    // step registers out of order
    drain();
    idle_en = 1'b1;
    program_regs(9'd32, 8'd140, 8'd255, 8'd200, 8'd50, 8'd10);
    run_phase(PHASE_ITEMS);

    drain();
    program_regs(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(PHASE_ITEMS);

    drain();
    idle_en = 1'b0;
    program_regs(VIEWER_HEIGHT_RST, HORIZON_ROW_RST, WATER_LINE_RST, CLOSE_STEP_RST,
                 MID_STEP_RST, HAZE_STEP_RST);
    run_phase(PHASE_ITEMS);

    drain();
    $display("covered %0d samples, %0d ignored samples, %0d clears, %0d copies",
             n_samples, n_ignored, n_clears, n_copies);
    $display("checked %0d spans across %0d register settings plus reset values",
             model.spans_checked, n_settings);
    if (model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", model.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/vcor_pkg.sv
design/vcor_if.sv
design/vcor_front.sv
design/vcor_queue.sv
design/vcor_back.sv
design/voxel_column_occlusion_raster.sv
tb/voxel_column_occlusion_raster_tb.sv
